// ===== src/krt_pkg.sv =====
package krt_pkg;

    // Default table depth
    localparam int DEPTH_DEF = 16;

    // Fixed field widths
    localparam int KEY_W   = 31;
    localparam int QTY_W   = 16;
    localparam int PRICE_W = 24;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_LOOKUP   = 2'd2,
        OP_CHEAPEST = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_INSTOCK  = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_POST
    } t_state;

    // One stored record
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [QTY_W-1:0]   quantity;
        logic [PRICE_W-1:0] price;
    } t_rec;

    typedef struct packed {
        t_op                operation;
        logic [KEY_W-1:0]   key;
        logic [QTY_W-1:0]   quantity;
        logic [PRICE_W-1:0] price;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [KEY_W-1:0]   found_key;
        logic [QTY_W-1:0]   found_quantity;
        logic [PRICE_W-1:0] found_price;
        logic [COUNT_W-1:0] record_count;
    } t_out_item;

endpackage

// ===== src/krt_ram.sv =====
module krt_ram
    import krt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_rec          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_rec          o_rdata
);

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/keyed_record_table.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_in_data  (t_in_item)
// result    out        o_out_valid / i_out_stall o_out_data (t_out_item)
//
// One operation at a time. Each operation walks the records through the single read
// port of the record memory; a key match ends the walk early, except in a cheapest
// search, which always walks every record.
// Remove of a zero-quantity record then copies the tail down one place; nothing is
// copied when it is the last record.
// Reset (synchronous, active low) empties the table; memory contents are not cleared.
// A stalled result sits in the output register while the next item is accepted.
module keyed_record_table
    import krt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_held, n_held;
    logic [CW-1:0]     r_addr, n_addr;
    logic              r_dvalid, n_dvalid;
    logic [AW-1:0]     r_didx, n_didx;
    t_in_item          r_req, n_req;
    t_rec              r_best, n_best;
    t_out_item         r_res, n_res;
    t_out_item         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_rec              ram_wdata;
    logic              ram_re;
    t_rec              rd;

    logic              more;
    logic              hit;
    logic              full;
    t_rec              req_rec;

    krt_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rd)
    );

    function automatic t_out_item make_res(t_status st, t_rec rec, logic [CW-1:0] cnt);
        t_out_item res;
        res.status         = st;
        res.found_key      = rec.key;
        res.found_quantity = rec.quantity;
        res.found_price    = rec.price;
        res.record_count   = COUNT_W'(cnt);
        return res;
    endfunction

    assign more    = (r_addr < r_held);
    assign hit     = r_dvalid && (rd.key == r_req.key) && (r_req.operation != OP_CHEAPEST);
    assign full    = (r_held == CW'(DEPTH));
    assign req_rec = '{key: r_req.key, quantity: r_req.quantity, price: r_req.price};

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_addr      = r_addr;
        n_dvalid    = r_dvalid;
        n_didx      = r_didx;
        n_req       = r_req;
        n_best      = r_best;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_didx - AW'(1);
        ram_wdata   = rd;
        ram_re      = 1'b0;

        // result transfer frees the output register
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req    = i_in_data;
                    n_addr   = '0;
                    n_dvalid = 1'b0;
                    n_state  = S_SCAN;
                end
            end

            S_SCAN: begin
                // running minimum, first lowest wins
                if (r_dvalid && (r_req.operation == OP_CHEAPEST)
                    && ((r_didx == '0) || (rd.price < r_best.price))) begin
                    n_best = rd;
                end
                // issue next read
                if (more && !hit) begin
                    ram_re   = 1'b1;
                    n_didx   = r_addr[AW-1:0];
                    n_dvalid = 1'b1;
                    n_addr   = r_addr + CW'(1);
                end else begin
                    n_dvalid = 1'b0;
                end

                if (hit) begin
                    n_state = S_POST;
                    case (r_req.operation)
                        OP_INSERT: n_res = make_res(ST_DUP, '0, r_held);
                        OP_REMOVE: begin
                            if (rd.quantity != '0) begin
                                n_res = make_res(ST_INSTOCK, rd, r_held);
                            end else begin
                                n_best   = rd;
                                n_addr   = CW'(r_didx) + CW'(1);
                                n_dvalid = 1'b0;
                                n_state  = S_SHIFT;
                            end
                        end
                        default: n_res = make_res(ST_OK, rd, r_held);
                    endcase
                end else if (!r_dvalid && !more) begin
                    // walk finished without a key match
                    n_state = S_POST;
                    case (r_req.operation)
                        OP_INSERT: begin
                            if (full) begin
                                n_res = make_res(ST_FULL, '0, r_held);
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_held[AW-1:0];
                                ram_wdata = req_rec;
                                n_held    = r_held + CW'(1);
                                n_res     = make_res(ST_OK, req_rec, r_held + CW'(1));
                            end
                        end
                        OP_CHEAPEST: begin
                            if (r_held == '0) begin
                                n_res = make_res(ST_EMPTY, '0, r_held);
                            end else begin
                                n_res = make_res(ST_OK, r_best, r_held);
                            end
                        end
                        default: n_res = make_res(ST_NOTFOUND, '0, r_held);
                    endcase
                end
            end

            S_SHIFT: begin
                // copy each later record one place down
                if (r_dvalid) begin
                    ram_we = 1'b1;
                end
                if (more) begin
                    ram_re   = 1'b1;
                    n_didx   = r_addr[AW-1:0];
                    n_dvalid = 1'b1;
                    n_addr   = r_addr + CW'(1);
                end else begin
                    n_dvalid = 1'b0;
                end
                if (!r_dvalid && !more) begin
                    n_held  = r_held - CW'(1);
                    n_res   = make_res(ST_OK, r_best, r_held - CW'(1));
                    n_state = S_POST;
                end
            end

            S_POST: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_dvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_dvalid    <= n_dvalid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_didx <= n_didx;
        r_req  <= n_req;
        r_best <= n_best;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CW'(DEPTH))
        else $error("record count above depth");

    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(r_held))
        else $error("record count moved outside an operation");

    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (CW'(ram_waddr) <= r_held))
        else $error("write beyond held records");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_EMPTY)) |-> (o_out_data.record_count == '0))
        else $error("empty reported with records held");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_FULL))
        |-> (o_out_data.record_count == COUNT_W'(DEPTH)))
        else $error("full reported below depth");

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import krt_pkg::*;

    localparam int TBL_DEPTH   = DEPTH_DEF;
    localparam int RAND_ITEMS  = 950;
    localparam int KEY_POOL_SZ = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT = 500000;

    localparam logic [KEY_W-1:0]   KEY_TOP   = '1;
    localparam logic [QTY_W-1:0]   QTY_TOP   = '1;
    localparam logic [PRICE_W-1:0] PRICE_TOP = '1;
    localparam logic [KEY_W-1:0]   FILL_BASE = 31'h0000_1000;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    // One directed row: the request, and a hand-written result where it is obvious
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_row;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    // Shadow copy of the record table
    logic [KEY_W-1:0]   rec_key   [TBL_DEPTH];
    logic [QTY_W-1:0]   rec_qty   [TBL_DEPTH];
    logic [PRICE_W-1:0] rec_price [TBL_DEPTH];
    int                 rec_held;

    t_out_item          due_results [$];
    t_row               script [$];
    logic [KEY_W-1:0]   key_pool [KEY_POOL_SZ];
    int                 fail_count;
    bit                 hold_req;

    keyed_record_table #(
        .DEPTH(TBL_DEPTH)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Apply one operation to the shadow table and return its result
    function automatic t_out_item table_apply(input t_in_item it);
        t_out_item r;
        int        pos;
        int        best;
        int        i;
        r = '0;
        r.status = ST_OK;
        pos = -1;
        for (i = 0; i < rec_held; i++) begin
            if (pos < 0 && rec_key[i] == it.key) pos = i;
        end
        case (it.operation)
            OP_INSERT: begin
                if (pos >= 0) begin
                    r.status = ST_DUP;
                end else if (rec_held >= TBL_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    rec_key[rec_held]   = it.key;
                    rec_qty[rec_held]   = it.quantity;
                    rec_price[rec_held] = it.price;
                    r.found_key      = it.key;
                    r.found_quantity = it.quantity;
                    r.found_price    = it.price;
                    rec_held++;
                end
            end
            OP_REMOVE, OP_LOOKUP: begin
                if (pos < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.found_key      = rec_key[pos];
                    r.found_quantity = rec_qty[pos];
                    r.found_price    = rec_price[pos];
                    if (it.operation == OP_REMOVE) begin
                        if (rec_qty[pos] != '0) begin
                            r.status = ST_INSTOCK;
                        end else begin
                            // close the gap, keeping insertion order
                            for (i = pos; i + 1 < rec_held; i++) begin
                                rec_key[i]   = rec_key[i+1];
                                rec_qty[i]   = rec_qty[i+1];
                                rec_price[i] = rec_price[i+1];
                            end
                            rec_held--;
                        end
                    end
                end
            end
            default: begin
                if (rec_held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // first record with the strictly lowest price wins
                    best = 0;
                    for (i = 1; i < rec_held; i++) begin
                        if (rec_price[i] < rec_price[best]) best = i;
                    end
                    r.found_key      = rec_key[best];
                    r.found_quantity = rec_qty[best];
                    r.found_price    = rec_price[best];
                end
            end
        endcase
        r.record_count = COUNT_W'(rec_held);
        return r;
    endfunction

    task automatic add_typed(
        input t_op op, input logic [KEY_W-1:0] key, input logic [QTY_W-1:0] qty,
        input logic [PRICE_W-1:0] price, input t_status st,
        input logic [KEY_W-1:0] fkey, input logic [QTY_W-1:0] fqty,
        input logic [PRICE_W-1:0] fprice, input logic [COUNT_W-1:0] cnt
    );
        t_row row;
        row.item  = '{op, key, qty, price};
        row.typed = 1'b1;
        row.want  = '{st, fkey, fqty, fprice, cnt};
        script.push_back(row);
    endtask

    task automatic add_pred(
        input t_op op, input logic [KEY_W-1:0] key, input logic [QTY_W-1:0] qty,
        input logic [PRICE_W-1:0] price
    );
        t_row row;
        row.item  = '{op, key, qty, price};
        row.typed = 1'b0;
        row.want  = '0;
        script.push_back(row);
    endtask

    // Random request; the bias leans toward filling or draining the table
    function automatic t_in_item rand_request(input bit filling);
        t_in_item it;
        int       pick;
        pick = $urandom_range(0, 99);
        if (filling) begin
            if (pick < 50)      it.operation = OP_INSERT;
            else if (pick < 70) it.operation = OP_REMOVE;
            else if (pick < 85) it.operation = OP_LOOKUP;
            else                it.operation = OP_CHEAPEST;
        end else begin
            if (pick < 20)      it.operation = OP_INSERT;
            else if (pick < 65) it.operation = OP_REMOVE;
            else if (pick < 85) it.operation = OP_LOOKUP;
            else                it.operation = OP_CHEAPEST;
        end
        // mostly keys from a small pool so that hits are common
        if ($urandom_range(0, 9) == 0) it.key = KEY_W'($urandom);
        else                           it.key = key_pool[$urandom_range(0, KEY_POOL_SZ-1)];
        if (it.operation == OP_INSERT) begin
            // stocked records can never leave, so keep them rare
            it.quantity = ($urandom_range(0, 24) == 0) ? QTY_W'($urandom) : '0;
            it.price    = $urandom_range(0, 1) ? PRICE_W'($urandom_range(0, 15))
                                               : PRICE_W'($urandom);
        end else begin
            it.quantity = QTY_W'($urandom);
            it.price    = PRICE_W'($urandom);
        end
        return it;
    endfunction

    // Offer one request after a gap, wait for its transfer, then predict it
    task automatic issue(
        input t_in_item it, input bit typed, input t_out_item want, input int gap
    );
        t_out_item model_out;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        model_out = table_apply(it);
        due_results.push_back(typed ? want : model_out);
    endtask

    // Drop valid and hold off until every pending result is back
    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
    endtask

    task automatic check_result(input t_out_item got, input t_out_item want);
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.found_key !== want.found_key) begin
            $error("found_key: expected %0h, got %0h", want.found_key, got.found_key);
            fail_count++;
        end
        if (got.found_quantity !== want.found_quantity) begin
            $error("found_quantity: expected %0h, got %0h",
                   want.found_quantity, got.found_quantity);
            fail_count++;
        end
        if (got.found_price !== want.found_price) begin
            $error("found_price: expected %0h, got %0h", want.found_price, got.found_price);
            fail_count++;
        end
        if (got.record_count !== want.record_count) begin
            $error("record_count: expected %0d, got %0d",
                   want.record_count, got.record_count);
            fail_count++;
        end
    endtask

    // Result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (due_results.size() == 0) begin
                $error("result transfer with nothing pending");
                fail_count++;
            end else begin
                check_result(out_data, due_results.pop_front());
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_cnt;
        int       tick;
        bit       hold_taken;
        bit       stall_next;
        out_stall  = 1'b0;
        mode       = RX_FREE;
        mode_left  = 0;
        hold_cnt   = 0;
        tick       = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge clk);
            tick++;
            if (hold_req && !hold_taken) begin
                hold_cnt   = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            if (hold_cnt > 0) begin
                hold_cnt--;
                stall_next = 1'b1;
            end else begin
                case (mode)
                    RX_LIGHT:    stall_next = ($urandom_range(0, 99) < 30);
                    RX_HEAVY:    stall_next = ($urandom_range(0, 99) < 70);
                    RX_PERIODIC: stall_next = ((tick % 4) == 3);
                    default:     stall_next = 1'b0;
                endcase
            end
            out_stall <= stall_next;
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus
    initial begin
        int n;
        int burst_left;
        int gap;
        bit filling;
        in_valid   = 1'b0;
        in_data    = '0;
        rst_n      = 1'b0;
        fail_count = 0;
        hold_req   = 1'b0;
        rec_held   = 0;
        for (n = 0; n < KEY_POOL_SZ; n++) key_pool[n] = KEY_W'($urandom);

        // Directed rows: empty table, extremes, every status
        add_typed(OP_CHEAPEST, 0, 0, 0, ST_EMPTY, 0, 0, 0, 0);
        add_typed(OP_REMOVE, KEY_TOP, QTY_TOP, PRICE_TOP, ST_NOTFOUND, 0, 0, 0, 0);
        add_typed(OP_INSERT, 0, 0, 0, ST_OK, 0, 0, 0, 1);
        add_typed(OP_INSERT, KEY_TOP, QTY_TOP, PRICE_TOP, ST_OK,
                  KEY_TOP, QTY_TOP, PRICE_TOP, 2);
        add_typed(OP_INSERT, 0, 16'h1234, 24'h000055, ST_DUP, 0, 0, 0, 2);
        add_typed(OP_CHEAPEST, KEY_TOP, QTY_TOP, PRICE_TOP, ST_OK, 0, 0, 0, 2);
        add_typed(OP_REMOVE, KEY_TOP, 0, 0, ST_INSTOCK, KEY_TOP, QTY_TOP, PRICE_TOP, 2);
        add_typed(OP_LOOKUP, KEY_TOP, 0, 0, ST_OK, KEY_TOP, QTY_TOP, PRICE_TOP, 2);
        // fill to the top, with price ties for the cheapest search
        for (n = 0; n < TBL_DEPTH - 2; n++) begin
            add_pred(OP_INSERT, FILL_BASE + KEY_W'(n * 7), 0,
                     (n % 3 == 0) ? PRICE_W'(20) : PRICE_W'(500 + n));
        end
        add_typed(OP_INSERT, 31'h2AAA_AAAA, QTY_TOP, PRICE_TOP, ST_FULL, 0, 0, 0, 16);
        // duplicate check ranks ahead of the full check
        add_typed(OP_INSERT, 0, 0, 0, ST_DUP, 0, 0, 0, 16);
        // removing the head shifts the whole table down
        add_typed(OP_REMOVE, 0, 0, 0, ST_OK, 0, 0, 0, 15);
        add_pred(OP_CHEAPEST, 0, 0, 0);
        add_pred(OP_REMOVE, FILL_BASE + KEY_W'(49), 0, 0);
        add_pred(OP_LOOKUP, FILL_BASE + KEY_W'(91), 0, 0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i]) begin
            issue(script[i].item, script[i].typed, script[i].want,
                  ($urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 6));
        end
        pause_until_drained();

        // Random part in bursts with random gaps
        burst_left = 0;
        filling    = 1'b0;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 60 == 0) filling = !filling;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
            end else begin
                gap = 0;
            end
            burst_left--;
            if (n == 400) hold_req = 1'b1;
            if (n == 700) pause_until_drained();
            issue(rand_request(filling), 1'b0, '0, gap);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
